// ===== src/psl_pkg.sv =====
// ----------------------------------------------------------------------------
// psl_pkg: shared types and constants of the punctuation and string lexer
// Holds the transaction structs, the token kind and error codes, the source
// character codes the lexer reacts to, and the default widths.
// ----------------------------------------------------------------------------
package psl_pkg;

	localparam int OFFSET_BITS_DEF = 16;
	localparam int LINE_BITS_DEF   = 16;

	// Depth of the result queue; it must hold at least two results.
	localparam int RESQ_DEPTH = 4;

	// Token kinds.
	localparam logic [4:0] K_LPAREN    = 5'd0;
	localparam logic [4:0] K_RPAREN    = 5'd1;
	localparam logic [4:0] K_LBRACE    = 5'd2;
	localparam logic [4:0] K_RBRACE    = 5'd3;
	localparam logic [4:0] K_COMMA     = 5'd4;
	localparam logic [4:0] K_DOT       = 5'd5;
	localparam logic [4:0] K_MINUS     = 5'd6;
	localparam logic [4:0] K_PLUS      = 5'd7;
	localparam logic [4:0] K_SEMICOLON = 5'd8;
	localparam logic [4:0] K_STAR      = 5'd9;
	localparam logic [4:0] K_SLASH     = 5'd10;
	localparam logic [4:0] K_BANG      = 5'd11;
	localparam logic [4:0] K_EQUAL     = 5'd13;
	localparam logic [4:0] K_GREATER   = 5'd15;
	localparam logic [4:0] K_LESS      = 5'd17;
	localparam logic [4:0] K_STRING    = 5'd19;
	localparam logic [4:0] K_ERROR     = 5'd20;
	localparam logic [4:0] K_EOF       = 5'd21;

	// Error codes.
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_UNTERM_STR = 2'd1;
	localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

	// Source characters.
	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_BANG      = 8'h21;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_PLUS      = 8'h2B;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_SEMICOLON = 8'h3B;
	localparam logic [7:0] CH_LESS      = 8'h3C;
	localparam logic [7:0] CH_EQUAL     = 8'h3D;
	localparam logic [7:0] CH_GREATER   = 8'h3E;
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;

	typedef struct packed {
		logic [7:0] ch;
		logic       at_end;
	} psl_in_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start_offset;
		logic [15:0] length;
		logic [15:0] line_number;
		logic [1:0]  error_code;
		logic        last;
	} psl_res_t;

	// Up to two results written into the queue in one cycle.
	typedef struct packed {
		logic [1:0] cnt;
		psl_res_t   r0;
		psl_res_t   r1;
	} psl_push_t;

endpackage

// ===== src/psl_core.sv =====
// ----------------------------------------------------------------------------
// psl_core: lexer state and per-byte decode
// Updates the scanner state for each accepted byte and forms the zero, one
// or two tokens that the byte decides, in order.
// ----------------------------------------------------------------------------
module psl_core import psl_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int LINE_BITS   = LINE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  psl_in_t   item,
	output psl_push_t push
);

	localparam int CW = (OFFSET_BITS + 1 > 16) ? OFFSET_BITS + 1 : 16;

	typedef enum logic [2:0] {
		M_IDLE, M_SLASH, M_OP, M_LINE, M_BLOCK, M_STRING
	} mode_t;

	mode_t                  mode_q, mode_n;
	logic [4:0]             pend_q, pend_n;
	logic                   star_q, star_n;
	logic [OFFSET_BITS-1:0] pos_q, pos_n, ts_q, ts_n, pos_inc;
	logic [LINE_BITS-1:0]   line_q, line_n, line_inc;
	logic [15:0]            len_cur, len_inc;
	logic                   eos;
	logic                   p_v, m_v, e_v;
	psl_res_t               p_r, m_r, e_r;

	function automatic logic [15:0] sat16(input logic [CW-1:0] v);
		return (v > CW'(16'hFFFF)) ? 16'hFFFF : 16'(v);
	endfunction

	function automatic psl_res_t mk(input logic [4:0] k, input logic [15:0] st,
			input logic [15:0] ln, input logic [1:0] er, input logic [15:0] lc);
		psl_res_t r;
		r.kind         = k;
		r.start_offset = st;
		r.length       = ln;
		r.line_number  = lc;
		r.error_code   = er;
		r.last         = 1'b0;
		return r;
	endfunction

	assign pos_inc  = (pos_q == '1) ? pos_q : pos_q + 1'b1;
	assign line_inc = (line_q == '1) ? line_q : line_q + 1'b1;
	assign len_cur  = sat16(CW'(pos_q) - CW'(ts_q));
	assign len_inc  = sat16(CW'(pos_q) + CW'(1) - CW'(ts_q));
	assign eos      = item.at_end | (item.ch == CH_NUL);

	always_comb begin
		logic  done;
		mode_t eff;
		done   = 1'b0;
		eff    = mode_q;
		mode_n = mode_q;
		pend_n = pend_q;
		star_n = star_q;
		pos_n  = pos_q;
		ts_n   = ts_q;
		line_n = line_q;
		p_v    = 1'b0;
		m_v    = 1'b0;
		e_v    = 1'b0;
		p_r    = mk(K_SLASH, 16'(ts_q), len_cur, ERR_NONE, 16'(line_q));
		m_r    = p_r;
		e_r    = mk(K_EOF, 16'(pos_q), 16'd0, ERR_NONE, 16'(line_q));

		// A held slash or operator is settled by this byte first.
		if (mode_q == M_SLASH) begin
			if (!eos && (item.ch == CH_SLASH || item.ch == CH_STAR)) begin
				mode_n = (item.ch == CH_SLASH) ? M_LINE : M_BLOCK;
				star_n = 1'b0;
				pos_n  = pos_inc;
				done   = 1'b1;
			end else begin
				p_v = 1'b1;
				eff = M_IDLE;
			end
		end else if (mode_q == M_OP) begin
			p_v = 1'b1;
			if (!eos && item.ch == CH_EQUAL) begin
				p_r    = mk(pend_q + 5'd1, 16'(ts_q), len_inc, ERR_NONE, 16'(line_q));
				mode_n = M_IDLE;
				pend_n = 5'd0;
				pos_n  = pos_inc;
				done   = 1'b1;
			end else begin
				p_r    = mk(pend_q, 16'(ts_q), len_cur, ERR_NONE, 16'(line_q));
				pend_n = 5'd0;
				eff    = M_IDLE;
			end
		end

		if (!done) begin
			if (eos) begin
				if (eff == M_STRING) begin
					m_v = 1'b1;
					m_r = mk(K_ERROR, 16'(ts_q), len_cur, ERR_UNTERM_STR, 16'(line_q));
				end
				e_v    = 1'b1;
				mode_n = M_IDLE;
				pend_n = 5'd0;
				star_n = 1'b0;
				pos_n  = '0;
				ts_n   = '0;
				line_n = LINE_BITS'(1);
			end else begin
				mode_n = eff;
				unique case (eff)
					M_LINE: begin
						if (item.ch == CH_NEWLINE) begin
							line_n = line_inc;
							mode_n = M_IDLE;
						end
					end
					M_BLOCK: begin
						if (item.ch == CH_NEWLINE) line_n = line_inc;
						if (star_q && item.ch == CH_SLASH) mode_n = M_IDLE;
						star_n = (item.ch == CH_STAR);
					end
					M_STRING: begin
						if (item.ch == CH_NEWLINE) line_n = line_inc;
						if (item.ch == CH_QUOTE) begin
							m_v    = 1'b1;
							m_r    = mk(K_STRING, 16'(ts_q), len_inc, ERR_NONE, 16'(line_q));
							mode_n = M_IDLE;
						end
					end
					default: begin
						mode_n = M_IDLE;
						m_r    = mk(K_ERROR, 16'(pos_q), 16'd1, ERR_NONE, 16'(line_q));
						case (item.ch)
							CH_SPACE, CH_TAB, CH_CR: ;
							CH_NEWLINE: line_n = line_inc;
							default: begin
								ts_n = pos_q;
								m_v  = 1'b1;
								case (item.ch)
									CH_LPAREN:    m_r.kind = K_LPAREN;
									CH_RPAREN:    m_r.kind = K_RPAREN;
									CH_LBRACE:    m_r.kind = K_LBRACE;
									CH_RBRACE:    m_r.kind = K_RBRACE;
									CH_COMMA:     m_r.kind = K_COMMA;
									CH_DOT:       m_r.kind = K_DOT;
									CH_MINUS:     m_r.kind = K_MINUS;
									CH_PLUS:      m_r.kind = K_PLUS;
									CH_SEMICOLON: m_r.kind = K_SEMICOLON;
									CH_STAR:      m_r.kind = K_STAR;
									CH_SLASH: begin
										m_v    = 1'b0;
										mode_n = M_SLASH;
									end
									CH_BANG, CH_EQUAL, CH_GREATER, CH_LESS: begin
										m_v    = 1'b0;
										mode_n = M_OP;
										case (item.ch)
											CH_BANG:    pend_n = K_BANG;
											CH_EQUAL:   pend_n = K_EQUAL;
											CH_GREATER: pend_n = K_GREATER;
											default:    pend_n = K_LESS;
										endcase
									end
									CH_QUOTE: begin
										m_v    = 1'b0;
										mode_n = M_STRING;
									end
									default:      m_r.error_code = ERR_UNEXPECTED;
								endcase
							end
						endcase
					end
				endcase
				pos_n = pos_inc;
			end
		end
	end

	// Pack the candidates in order; at most two are ever valid together.
	always_comb begin
		push.r0 = p_v ? p_r : (m_v ? m_r : e_r);
		push.r1 = p_v ? (m_v ? m_r : e_r) : e_r;
		push.cnt = fire ? (2'(p_v) + 2'(m_v) + 2'(e_v)) : 2'd0;
		push.r0.last = (push.cnt == 2'd1);
		push.r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pend_q <= 5'd0;
			star_q <= 1'b0;
			pos_q  <= '0;
			ts_q   <= '0;
			line_q <= LINE_BITS'(1);
		end else if (fire) begin
			mode_q <= mode_n;
			pend_q <= pend_n;
			star_q <= star_n;
			pos_q  <= pos_n;
			ts_q   <= ts_n;
			line_q <= line_n;
		end
	end

endmodule

// ===== src/psl_resq.sv =====
// ----------------------------------------------------------------------------
// psl_resq: token result queue
// Small register queue that takes up to two tokens per cycle and hands one
// per cycle to the output channel while it is ready.
// ----------------------------------------------------------------------------
module psl_resq import psl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  psl_push_t push,
	output logic      room,
	output logic      valid,
	input  logic      ready,
	output psl_res_t  data
);

	localparam int PW = $clog2(RESQ_DEPTH);
	localparam int CNW = $clog2(RESQ_DEPTH + 1);

	psl_res_t         slot_q [RESQ_DEPTH];
	logic [PW-1:0]    head_q, tail_q;
	logic [CNW-1:0]   count_q;
	logic             pop;

	assign valid = (count_q != '0);
	assign data  = slot_q[head_q];
	assign pop   = valid & ready;
	// Room for the worst case of two tokens from one byte.
	assign room  = (count_q <= CNW'(RESQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) slot_q[tail_q] <= push.r0;
		if (push.cnt == 2'd2) slot_q[tail_q + PW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) head_q <= head_q + PW'(1);
			tail_q  <= tail_q + PW'(push.cnt);
			count_q <= count_q + CNW'(push.cnt) - CNW'(pop);
		end
	end

endmodule

// ===== src/punctuation_string_lexer.sv =====
// ----------------------------------------------------------------------------
// punctuation_string_lexer: streaming punctuation and string scanner
// Output: a token decided by a byte is offered from the result queue registers.
// Throughput: one source byte per cycle while the queue has room; a byte may yield up to two tokens.
// Reset: arst_n sets the scanner to line one, offset zero, and empties the queue.
// ----------------------------------------------------------------------------
module punctuation_string_lexer import psl_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int LINE_BITS   = LINE_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_ready,
	input  psl_in_t  byte_item,
	output logic     tok_valid,
	input  logic     tok_ready,
	output psl_res_t tok_item
);

	// The scanner state sits in the core and is updated in the same cycle in
	// which a byte transaction completes. The tokens that the byte decides are
	// written straight into the result queue, which registers them and parts
	// the byte side from the token side.
	//
	// The byte side is ready whenever the queue can take two more tokens, so
	// a stall on the token side only throttles bytes once the queue fills.
	// Ready does not depend on tok_ready combinationally.

	logic      fire;
	logic      room;
	psl_push_t push;

	assign byte_ready = room;
	assign fire       = byte_valid & byte_ready;

	// Scanner: mode, held operator, comment star flag, offset and line count.
	psl_core #(
		.OFFSET_BITS (OFFSET_BITS),
		.LINE_BITS   (LINE_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (byte_item),
		.push   (push)
	);

	// Result queue: absorbs the second token of a byte and any output stall.
	psl_resq u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.valid  (tok_valid),
		.ready  (tok_ready),
		.data   (tok_item)
	);

endmodule

// ===== dv/tb_punctuation_string_lexer.sv =====
// ----------------------------------------------------------------------------
// tb_punctuation_string_lexer: self-checking bench for the streaming lexer
// Feeds source bytes through the byte channel and checks every token on the
// token channel against a cycle-free scanner model kept in the bench. Runs
// directed sources, one long string across many lines and many random
// sources, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_punctuation_string_lexer;
	import psl_pkg::*;

	// Scanner modes of the bench's own lexer model.
	typedef enum logic [2:0] {
		LX_IDLE,
		LX_SLASH,
		LX_OP,
		LX_LINE,
		LX_BLOCK,
		LX_STRING
	} lex_mode_t;

	localparam int unsigned POS_MAX  = (1 << OFFSET_BITS_DEF) - 1;
	localparam int unsigned LINE_MAX = (1 << LINE_BITS_DEF) - 1;
	localparam int RANDOM_ITEMS = 1270;
	// Newlines inside the long string.
	localparam int LONG_NEWLINES = 40;
	// The watchdog limit lies far above the slowest legal stretch without a transaction.
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 16;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     byte_valid;
	logic     byte_ready;
	psl_in_t  byte_item;
	logic     tok_valid;
	logic     tok_ready;
	psl_res_t tok_item;

	// Idling bounds; the tests switch them between busy and bursty phases.
	int max_gap;
	int max_stall;

	int items_sent = 0;
	int mismatches = 0;

	// Tokens predicted but not yet seen, oldest first.
	psl_res_t tokens_due[$];

	// State of the lexer model.
	lex_mode_t   lx_mode;
	logic [7:0]  op_char;
	logic        star_seen;
	int unsigned src_pos;
	int unsigned tok_start;
	int unsigned line_cnt;

	// Tokens raised by the byte being modelled, before the last flag is set.
	psl_res_t byte_toks [2];
	int       byte_tok_cnt;

	string punct_text = "(){},.-+;*";
	string op_text    = "!=<>";
	string ws_text    = " \t\r\n";

	punctuation_string_lexer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item (byte_item),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_item  (tok_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Lexer model
	// ------------------------------------------------------------------

	function automatic void lexer_clear();
		lx_mode   = LX_IDLE;
		op_char   = CH_NUL;
		star_seen = 1'b0;
		src_pos   = 0;
		tok_start = 0;
		line_cnt  = 1;
	endfunction

	// Records one token for the current byte. The line number is taken at the
	// moment of the call, so a held token that is flushed by the following
	// byte still carries the line count from before that byte.
	function automatic void add_token(input logic [4:0] kind, input int unsigned start,
			input int unsigned len, input logic [1:0] err);
		psl_res_t t;
		t.kind         = kind;
		t.start_offset = start[15:0];
		t.length       = (len > 32'hFFFF) ? 16'hFFFF : len[15:0];
		t.line_number  = line_cnt[15:0];
		t.error_code   = err;
		t.last         = 1'b0;
		byte_toks[byte_tok_cnt] = t;
		byte_tok_cnt++;
	endfunction

	// Single-character punctuation kinds; K_ERROR stands for "not punctuation".
	function automatic logic [4:0] single_kind(input logic [7:0] c);
		case (c)
			CH_LPAREN:    return K_LPAREN;
			CH_RPAREN:    return K_RPAREN;
			CH_LBRACE:    return K_LBRACE;
			CH_RBRACE:    return K_RBRACE;
			CH_COMMA:     return K_COMMA;
			CH_DOT:       return K_DOT;
			CH_MINUS:     return K_MINUS;
			CH_PLUS:      return K_PLUS;
			CH_SEMICOLON: return K_SEMICOLON;
			CH_STAR:      return K_STAR;
			default:      return K_ERROR;
		endcase
	endfunction

	// The two-character form of each operator is the kind just above its bare form.
	function automatic logic [4:0] op_kind(input logic [7:0] c, input logic with_eq);
		logic [4:0] base;
		case (c)
			CH_BANG:    base = K_BANG;
			CH_EQUAL:   base = K_EQUAL;
			CH_GREATER: base = K_GREATER;
			default:    base = K_LESS;
		endcase
		return with_eq ? base + 5'd1 : base;
	endfunction

	// Advances the model by one accepted byte and queues the tokens it raises.
	function automatic void lex_byte(input logic [7:0] c, input logic at_end);
		logic       src_end;
		logic [4:0] sk;
		psl_res_t   t;
		src_end      = at_end || (c == CH_NUL);
		byte_tok_cnt = 0;

		if (lx_mode == LX_SLASH && !src_end && (c == CH_SLASH || c == CH_STAR)) begin
			// The held slash opens a comment instead of becoming a token.
			lx_mode   = (c == CH_SLASH) ? LX_LINE : LX_BLOCK;
			star_seen = 1'b0;
			if (src_pos < POS_MAX)
				src_pos++;
		end else if (lx_mode == LX_OP && !src_end && c == CH_EQUAL) begin
			add_token(op_kind(op_char, 1'b1), tok_start, src_pos + 1 - tok_start, ERR_NONE);
			lx_mode = LX_IDLE;
			op_char = CH_NUL;
			if (src_pos < POS_MAX)
				src_pos++;
		end else begin
			// A held slash or operator that this byte does not extend goes out first.
			if (lx_mode == LX_SLASH) begin
				add_token(K_SLASH, tok_start, src_pos - tok_start, ERR_NONE);
				lx_mode = LX_IDLE;
			end else if (lx_mode == LX_OP) begin
				add_token(op_kind(op_char, 1'b0), tok_start, src_pos - tok_start, ERR_NONE);
				lx_mode = LX_IDLE;
				op_char = CH_NUL;
			end

			if (src_end) begin
				// An open string is reported; an open block comment just ends.
				if (lx_mode == LX_STRING)
					add_token(K_ERROR, tok_start, src_pos - tok_start, ERR_UNTERM_STR);
				add_token(K_EOF, src_pos, 0, ERR_NONE);
				lexer_clear();
			end else begin
				// Every mode counts newlines, comments and strings included.
				if (c == CH_NEWLINE && line_cnt < LINE_MAX)
					line_cnt++;
				case (lx_mode)
					LX_LINE: begin
						if (c == CH_NEWLINE)
							lx_mode = LX_IDLE;
					end
					LX_BLOCK: begin
						if (star_seen && c == CH_SLASH)
							lx_mode = LX_IDLE;
						star_seen = (c == CH_STAR);
					end
					LX_STRING: begin
						if (c == CH_QUOTE) begin
							add_token(K_STRING, tok_start, src_pos + 1 - tok_start, ERR_NONE);
							lx_mode = LX_IDLE;
						end
					end
					default: begin
						lx_mode = LX_IDLE;
						if (!(c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NEWLINE)) begin
							tok_start = src_pos;
							sk = single_kind(c);
							if (sk != K_ERROR) begin
								add_token(sk, src_pos, 1, ERR_NONE);
							end else if (c == CH_SLASH) begin
								lx_mode = LX_SLASH;
							end else if (c == CH_BANG || c == CH_EQUAL || c == CH_GREATER ||
									c == CH_LESS) begin
								lx_mode = LX_OP;
								op_char = c;
							end else if (c == CH_QUOTE) begin
								lx_mode = LX_STRING;
							end else begin
								add_token(K_ERROR, src_pos, 1, ERR_UNEXPECTED);
							end
						end
					end
				endcase
				if (src_pos < POS_MAX)
					src_pos++;
			end
		end

		for (int i = 0; i < byte_tok_cnt; i++) begin
			t      = byte_toks[i];
			t.last = (i == byte_tok_cnt - 1);
			tokens_due.push_back(t);
		end
	endfunction

	function automatic void compare_token(input psl_res_t want, input psl_res_t got);
		if (got.kind !== want.kind) begin
			$error("kind: expected %0d, got %0d", want.kind, got.kind);
			mismatches++;
		end
		if (got.start_offset !== want.start_offset) begin
			$error("start_offset: expected %0d, got %0d", want.start_offset, got.start_offset);
			mismatches++;
		end
		if (got.length !== want.length) begin
			$error("length: expected %0d, got %0d", want.length, got.length);
			mismatches++;
		end
		if (got.line_number !== want.line_number) begin
			$error("line_number: expected %0d, got %0d", want.line_number, got.line_number);
			mismatches++;
		end
		if (got.error_code !== want.error_code) begin
			$error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
			mismatches++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last);
			mismatches++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Monitor: both channels are sampled at the rising edge in one process,
	// so a byte is always modelled before any token it could have raised is
	// checked, whatever the latency of the block turns out to be.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && byte_ready)
				lex_byte(byte_item.ch, byte_item.at_end);
			if (tok_valid && tok_ready) begin
				if (tokens_due.size() == 0) begin
					$error("unexpected token: kind %0d, start_offset %0d",
						tok_item.kind, tok_item.start_offset);
					mismatches++;
				end else begin
					compare_token(tokens_due.pop_front(), tok_item);
				end
			end
		end
	end

	// Watchdog: ends the run if no transaction happens on either channel for
	// far longer than any legal stall could last.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((byte_valid && byte_ready) || (tok_valid && tok_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_punctuation_string_lexer: FAIL");
		$finish;
	end

	// Token receiver: for every transaction it draws a stall, holds ready low
	// that long, then raises ready and waits for a token to be taken.
	initial begin : token_sink
		int stall;
		tok_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, max_stall);
			if (stall > 0) begin
				@(negedge clk);
				tok_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			tok_ready <= 1'b1;
			do @(posedge clk); while (!tok_valid);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Offers one byte after a random gap and returns once it has been taken.
	// Valid is left high, so a back-to-back byte only changes the payload.
	task automatic send_byte(input logic [7:0] c, input logic at_end);
		int      gap;
		psl_in_t nxt;
		gap        = $urandom_range(0, max_gap);
		nxt.ch     = c;
		nxt.at_end = at_end;
		@(negedge clk);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_item  <= nxt;
		do @(posedge clk); while (!byte_ready);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	// Random body byte for comments and strings; newlines and stars are
	// favoured, and the byte that would close the construct is avoided.
	function automatic logic [7:0] body_byte(input logic [7:0] stop);
		logic [7:0] b;
		do begin
			case ($urandom_range(0, 3))
				0:       b = CH_NEWLINE;
				1:       b = CH_STAR;
				default: b = 8'($urandom_range(1, 255));
			endcase
		end while (b == stop);
		return b;
	endfunction

	// Every punctuation token, with the source closed by at_end carrying an
	// all-ones byte that must be ignored.
	task automatic test_punctuation();
		send_text(punct_text);
		send_byte(8'hFF, 1'b1);
	endtask

	// All four two-character operators, then the four bare ones, each flushed
	// by the next byte; the last is flushed by a zero byte together with EOF.
	task automatic test_operators();
		send_text("!===<=>==!><");
		send_byte(CH_NUL, 1'b0);
	endtask

	// A held slash flushed by a plus and by end of source (at_end with a slash
	// byte, which must not open a comment), then an unterminated block comment.
	task automatic test_comments();
		send_text("/+/");
		send_byte(CH_SLASH, 1'b1);
		send_text("/**");
		send_byte(CH_NUL, 1'b0);
	endtask

	// A string across a newline, unexpected characters, and a string left open
	// at end of source, which gives an error token followed by EOF.
	task automatic test_strings_errors();
		send_text("\"\n\"#");
		send_byte(8'hFF, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_NUL, 1'b1);
	endtask

	// One source without gaps: a string spanning many lines, followed by a
	// punctuation token that must carry the advanced offset and line count.
	task automatic test_long_string();
		max_gap = 0;
		send_byte(CH_QUOTE, 1'b0);
		repeat (LONG_NEWLINES) send_byte(CH_NEWLINE, 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_byte(CH_LPAREN, 1'b0);
		send_byte(CH_NUL, 1'b0);
	endtask

	// Random sources built mostly from well-formed lexemes with random
	// content; comments and strings are sometimes left open, and stray bytes
	// are mixed in. Each source picks its own idling on both channels.
	task automatic test_random();
		int   stop_at;
		int   target;
		logic cut;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 12;
			max_stall = ($urandom_range(0, 3) == 0) ? 0 : 12;
			target    = items_sent + $urandom_range(4, 60);
			while (items_sent < target) begin
				cut = ($urandom_range(0, 7) == 0);
				case ($urandom_range(0, 11))
					0, 1: send_byte(punct_text[$urandom_range(0, 9)], 1'b0);
					2, 3: begin
						send_byte(op_text[$urandom_range(0, 3)], 1'b0);
						if ($urandom_range(0, 1))
							send_byte(CH_EQUAL, 1'b0);
					end
					4: send_byte(ws_text[$urandom_range(0, 3)], 1'b0);
					5: begin
						send_text("//");
						repeat ($urandom_range(0, 6)) send_byte(body_byte(CH_NEWLINE), 1'b0);
						if (!cut)
							send_byte(CH_NEWLINE, 1'b0);
					end
					6: begin
						send_text("/*");
						repeat ($urandom_range(0, 8)) send_byte(body_byte(CH_SLASH), 1'b0);
						if (!cut)
							send_text("*/");
					end
					7, 8: begin
						send_byte(CH_QUOTE, 1'b0);
						repeat ($urandom_range(0, 8)) send_byte(body_byte(CH_QUOTE), 1'b0);
						if (!cut)
							send_byte(CH_QUOTE, 1'b0);
					end
					9:  send_byte(CH_SLASH, 1'b0);
					10: send_byte(8'($urandom_range(1, 255)), 1'b0);
					default: send_byte(CH_NEWLINE, 1'b0);
				endcase
			end
			// Close the source either with at_end and a random byte or with a zero byte.
			if ($urandom_range(0, 1))
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			else
				send_byte(CH_NUL, 1'b0);
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		byte_item  = '0;
		max_gap    = 12;
		max_stall  = 12;
		lexer_clear();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_punctuation();
		test_operators();
		test_comments();
		test_strings_errors();
		test_long_string();
		test_random();

		// Stop offering bytes, let every predicted token arrive, then give the
		// block a few more cycles to show any token nobody asked for.
		@(negedge clk);
		byte_valid <= 1'b0;
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("tb_punctuation_string_lexer: PASS");
		end else begin
			$display("tb_punctuation_string_lexer: FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/psl_pkg.sv
src/psl_core.sv
src/psl_resq.sv
src/punctuation_string_lexer.sv
dv/tb_punctuation_string_lexer.sv
